>>> design/spvk_pkg.sv
// Shared widths, constants and the side-band struct of the Stokes kernel pipeline.
// No dependencies; every other design file imports it.
package spvk_pkg;

  localparam int COORD_W     = 32;
  localparam int DIFF_W      = 33;
  localparam int MAG_W       = 33;
  localparam int SUM_W       = 66;
  localparam int ROOT_W      = 63;
  localparam int REM_SQ_W    = 65;
  localparam int SQRT_STEPS  = 63;
  localparam int S_PAIRS     = 33;
  localparam int DIV_STEPS   = 57;
  localparam int DIV_REM_W   = 64;
  localparam int QUO_W       = 57;
  localparam int DIV_LANES   = 4;
  localparam int WORD_W      = 64;
  localparam int ENTRY_W     = 48;
  localparam int FLOOR_W     = 32;
  localparam int FLOOR_SQ_W  = 64;
  localparam int ROW_W       = 2;
  localparam int MUL_LAT     = 3;
  localparam int FRONT_LAT   = 3;
  localparam int W_DLY       = 2 * MUL_LAT;
  localparam int Z_DLY       = 3 * MUL_LAT;
  localparam int PIPE_LAT    = FRONT_LAT + SQRT_STEPS + DIV_STEPS + 3 * MUL_LAT;
  localparam int U_PRESHIFT  = 13;
  localparam int W_INIT_SH   = 29;
  localparam int Q40_SH      = 40;
  localparam int Q56_SH      = 56;

  localparam logic [WORD_W-1:0]  C4_Q40   = 64'd87496355274;
  localparam logic [WORD_W-1:0]  C8_Q40   = 64'd43748177637;
  localparam logic [WORD_W-1:0]  ONE_Q40  = 64'h0000_0100_0000_0000;
  localparam logic [WORD_W-1:0]  BIG_CAP  = 64'h4000_0000_0000_0000;
  localparam logic [WORD_W-1:0]  SAT_POS  = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0]  SAT_NEG  = 64'h0000_8000_0000_0000;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 32'd1;
  localparam logic [ROW_W-1:0]   ROW_LAST = 2'd3;

  // Side-band that rides along the root and divider pipelines.
  typedef struct packed {
    logic                    zero;
    logic [2:0]              neg;
    logic [2:0][MAG_W-1:0]   mag;
  } spvk_side_t;

endpackage

>>> design/stokes_pressure_velocity_kernel_core.sv
// Stokes pressure/velocity kernel: top level with front end, multiplier tree and row output.
// Depends on spvk_pkg, spvk_sqrt, spvk_div and spvk_mul.
//
// Usage. Each input item on the in_ stream is one target/source point pair in signed
// Q16.16. The block forms r = target - source and returns the 4x4 kernel matrix as four
// output items on the out_ stream, one per row, row index on out_tuser and the fourth
// row marked by out_tlast. Entries are signed Q24.24, clamped to 48 bits. Pairs closer
// than the distance floor (cfg_ port, unsigned Q16.16, 2^-16 after reset) give all zeros.
// The floor may only be rewritten while no item is in flight.
// An accepted item passes three front-end stages, 63 root stages, 57 divider stages,
// three multiplier levels of three stages each and the output register before its
// first row appears. The four rows share the single output channel, so an item leaves
// only as fast as its rows are taken; the pipeline itself takes one item per cycle
// while not held. When a finished matrix waits at the tail, the whole pipeline holds
// (a common enable), so nothing is lost or repeated; in_tready drops only then.
// Reset (rst_n low, synchronous) empties the pipeline and the output register and
// restores the floor.
module stokes_pressure_velocity_kernel_core import spvk_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // target_x, target_y, target_z, source_x, source_y, source_z (32 bits each)
  input  logic [191:0]        in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // entry_fx, entry_fy, entry_fz, entry_trace (48 bits each)
  output logic [191:0]        out_tdata,
  // row_index
  output logic [ROW_W-1:0]    out_tuser,
  output logic                out_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [FLOOR_W-1:0]  cfg_data
);

  // Configuration: the floor and its square, which is what the front end compares.
  logic [FLOOR_W-1:0]    floor_r;
  logic [FLOOR_SQ_W-1:0] floor_sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r    <= FLOOR_RESET;
      floor_sq_r <= FLOOR_SQ_W'(FLOOR_RESET);
    end else begin
      if (cfg_valid) begin
        floor_r <= cfg_data;
      end
      floor_sq_r <= {32'd0, floor_r} * {32'd0, floor_r};
    end
  end

  // Common pipeline enable: everything advances unless a finished matrix is
  // stuck at the tail because the output register is still busy.
  logic en;
  logic load;
  logic tail_v;
  logic valid_r [0:PIPE_LAT-1];

  assign tail_v    = valid_r[PIPE_LAT-1];
  assign en        = !tail_v || load;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= in_tvalid;
      for (int i = 1; i < PIPE_LAT; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  // Front end: difference vector, its magnitudes, squares, |r|^2 and the floor test.
  logic [MAG_W-1:0]  mag1_r [0:2];
  logic [2:0]        neg1_r;
  logic [SUM_W-1:0]  sq2_r  [0:2];
  logic [MAG_W-1:0]  mag2_r [0:2];
  logic [2:0]        neg2_r;
  logic [SUM_W-1:0]  s3_r;
  logic              zero3_r;
  logic [MAG_W-1:0]  mag3_r [0:2];
  logic [2:0]        neg3_r;
  logic [SUM_W-1:0]  s_sum;

  for (genvar i = 0; i < 3; i++) begin : g_front
    logic [COORD_W-1:0] tc, sc;
    logic [DIFF_W-1:0]  diff;

    assign tc   = in_tdata[COORD_W*i +: COORD_W];
    assign sc   = in_tdata[COORD_W*(i+3) +: COORD_W];
    assign diff = {tc[COORD_W-1], tc} - {sc[COORD_W-1], sc};

    always_ff @(posedge clk) begin
      if (en) begin
        mag1_r[i] <= diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
        neg1_r[i] <= diff[DIFF_W-1];
        sq2_r[i]  <= {33'd0, mag1_r[i]} * {33'd0, mag1_r[i]};
        mag2_r[i] <= mag1_r[i];
        neg2_r[i] <= neg1_r[i];
        mag3_r[i] <= mag2_r[i];
        neg3_r[i] <= neg2_r[i];
      end
    end
  end

  assign s_sum = sq2_r[0] + sq2_r[1] + sq2_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r    <= s_sum;
      zero3_r <= (s_sum == '0) || (s_sum < {2'b00, floor_sq_r});
    end
  end

  spvk_side_t side3;
  spvk_side_t side_q;
  spvk_side_t side_d;
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0]  quo [0:DIV_LANES-1];

  always_comb begin
    side3.zero = zero3_r;
    side3.neg  = neg3_r;
    for (int i = 0; i < 3; i++) begin
      side3.mag[i] = mag3_r[i];
    end
  end

  spvk_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .s_in     (s3_r),
    .side_in  (side3),
    .root_out (root),
    .side_out (side_q)
  );

  spvk_div u_div (
    .clk      (clk),
    .en       (en),
    .root_in  (root),
    .side_in  (side_q),
    .quo_out  (quo),
    .side_out (side_d)
  );

  // Unit vector u (Q.40) and w = 1/|r| (Q.40), both as signed words.
  logic signed [WORD_W-1:0] w_val;
  logic signed [WORD_W-1:0] u_val [0:2];
  logic signed [WORD_W-1:0] w_dly_r [0:W_DLY-1];
  logic                     z_dly_r [0:Z_DLY-1];

  assign w_val = $signed(WORD_W'(quo[0]));
  for (genvar i = 0; i < 3; i++) begin : g_u
    assign u_val[i] = side_d.neg[i] ? $signed(~WORD_W'(quo[i+1]) + 1'b1)
                                    : $signed(WORD_W'(quo[i+1]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_dly_r[0] <= w_val;
      z_dly_r[0] <= side_d.zero;
      for (int i = 1; i < W_DLY; i++) begin
        w_dly_r[i] <= w_dly_r[i-1];
      end
      for (int i = 1; i < Z_DLY; i++) begin
        z_dly_r[i] <= z_dly_r[i-1];
      end
    end
  end

  // Multiplier tree: level one forms u_i*w and u_i*u_j, level two scales by the
  // 1/(4 pi) and 1/(8 pi) constants, level three multiplies by w again and clamps.
  logic signed [WORD_W-1:0] a_v   [0:2];
  logic signed [WORD_W-1:0] a4_v  [0:2];
  logic signed [WORD_W-1:0] a8_v  [0:2];
  logic signed [WORD_W-1:0] e0_v  [0:2];
  logic signed [WORD_W-1:0] tr_v  [0:2];
  logic signed [WORD_W-1:0] p_v   [0:2][0:2];
  logic signed [WORD_W-1:0] v8_v  [0:2][0:2];
  logic signed [WORD_W-1:0] e_v   [0:2][0:2];

  for (genvar i = 0; i < 3; i++) begin : g_vec
    logic signed [WORD_W-1:0] a8_neg;
    assign a8_neg = -a8_v[i];

    spvk_mul #(.SHIFT(Q40_SH), .CAP_POS(BIG_CAP), .CAP_NEG(BIG_CAP)) u_a (
      .clk(clk), .en(en), .a(u_val[i]), .b(w_val), .p(a_v[i]));
    spvk_mul #(.SHIFT(Q40_SH), .CAP_POS(BIG_CAP), .CAP_NEG(BIG_CAP)) u_a4 (
      .clk(clk), .en(en), .a(a_v[i]), .b($signed(C4_Q40)), .p(a4_v[i]));
    spvk_mul #(.SHIFT(Q40_SH), .CAP_POS(BIG_CAP), .CAP_NEG(BIG_CAP)) u_a8 (
      .clk(clk), .en(en), .a(a_v[i]), .b($signed(C8_Q40)), .p(a8_v[i]));
    spvk_mul #(.SHIFT(Q56_SH), .CAP_POS(SAT_POS), .CAP_NEG(SAT_NEG)) u_e0 (
      .clk(clk), .en(en), .a(a4_v[i]), .b(w_dly_r[W_DLY-1]), .p(e0_v[i]));
    spvk_mul #(.SHIFT(Q56_SH), .CAP_POS(SAT_POS), .CAP_NEG(SAT_NEG)) u_tr (
      .clk(clk), .en(en), .a(a8_neg), .b(w_dly_r[W_DLY-1]), .p(tr_v[i]));

    for (genvar j = 0; j < 3; j++) begin : g_mat
      logic signed [WORD_W-1:0] p_adj;
      // The identity term joins on the diagonal.
      if (i == j) begin : g_diag
        assign p_adj = p_v[i][j] + $signed(ONE_Q40);
      end else begin : g_off
        assign p_adj = p_v[i][j];
      end

      spvk_mul #(.SHIFT(Q40_SH), .CAP_POS(BIG_CAP), .CAP_NEG(BIG_CAP)) u_p (
        .clk(clk), .en(en), .a(u_val[i]), .b(u_val[j]), .p(p_v[i][j]));
      spvk_mul #(.SHIFT(Q40_SH), .CAP_POS(BIG_CAP), .CAP_NEG(BIG_CAP)) u_v8 (
        .clk(clk), .en(en), .a(p_adj), .b($signed(C8_Q40)), .p(v8_v[i][j]));
      spvk_mul #(.SHIFT(Q56_SH), .CAP_POS(SAT_POS), .CAP_NEG(SAT_NEG)) u_e (
        .clk(clk), .en(en), .a(v8_v[i][j]), .b(w_dly_r[W_DLY-1]), .p(e_v[i][j]));
    end
  end

  // Output register: holds one matrix and sends it row by row.
  logic [ENTRY_W-1:0] mat_r [0:3][0:3];
  logic [ENTRY_W-1:0] tail_ent [0:3][0:3];
  logic               tail_zero;
  logic               busy_r, busy_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               zero_r;
  logic               out_fire;
  logic               last_fire;

  assign tail_zero = z_dly_r[Z_DLY-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tail_ent[0][i]   = tail_zero ? '0 : e0_v[i][ENTRY_W-1:0];
      tail_ent[i+1][3] = tail_zero ? '0 : tr_v[i][ENTRY_W-1:0];
      for (int j = 0; j < 3; j++) begin
        tail_ent[i+1][j] = tail_zero ? '0 : e_v[i][j][ENTRY_W-1:0];
      end
    end
    // The pressure row has no trace coefficient.
    tail_ent[0][3] = '0;
  end

  assign out_fire  = busy_r && out_tready;
  assign last_fire = out_fire && (row_r == ROW_LAST);
  assign load      = tail_v && (!busy_r || last_fire);

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    if (load) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
    end else if (last_fire) begin
      busy_nxt = 1'b0;
    end else if (out_fire) begin
      row_nxt = row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mat_r  <= tail_ent;
      zero_r <= tail_zero;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tuser  = row_r;
  assign out_tlast  = (row_r == ROW_LAST);
  assign out_tdata  = {mat_r[row_r][3], mat_r[row_r][2], mat_r[row_r][1], mat_r[row_r][0]};

  // A matrix is only released after its fourth row has been taken.
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(out_tvalid && out_tready && (row_r == ROW_LAST)))
    else $error("output register emptied before the last row was taken");

  // Rows of one matrix are sent in order without gaps.
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && (row_r != ROW_LAST)) |=> (row_r == $past(row_r) + 1'b1))
    else $error("row index did not advance by one");

  // A pair below the floor yields zero entries on every row.
  a_zero_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && zero_r) |-> (out_tdata == '0))
    else $error("non-zero entry for a pair below the distance floor");

  // A finished matrix at the tail is never dropped while the output register is busy.
  a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_v && busy_r && !(out_tready && (row_r == ROW_LAST))) |-> !in_tready)
    else $error("pipeline advanced over a waiting matrix");

endmodule

>>> design/spvk_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on spvk_pkg; root = floor(sqrt(s * 2^60)).
module spvk_sqrt import spvk_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SUM_W-1:0]    s_in,
  input  spvk_side_t          side_in,
  output logic [ROOT_W-1:0]   root_out,
  output spvk_side_t          side_out
);

  logic [SUM_W-1:0]    s_r    [1:SQRT_STEPS];
  logic [REM_SQ_W-1:0] rem_r  [1:SQRT_STEPS];
  logic [ROOT_W-1:0]   root_r [1:SQRT_STEPS];
  spvk_side_t          side_r [1:SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_st
    logic [SUM_W-1:0]    s_cur;
    logic [REM_SQ_W-1:0] rem_cur;
    logic [ROOT_W-1:0]   root_cur;
    spvk_side_t          side_cur;
    logic [1:0]          pair;
    logic [REM_SQ_W+1:0] rem2;
    logic [REM_SQ_W+1:0] trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign s_cur    = s_in;
      assign rem_cur  = '0;
      assign root_cur = '0;
      assign side_cur = side_in;
    end else begin : g_next
      assign s_cur    = s_r[k];
      assign rem_cur  = rem_r[k];
      assign root_cur = root_r[k];
      assign side_cur = side_r[k];
    end

    // The operand is s followed by sixty zero bits.
    if (k < S_PAIRS) begin : g_pair
      assign pair = s_cur[SUM_W-1-2*k -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem2  = {rem_cur, pair};
    assign trial = {2'b00, root_cur, 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k+1]    <= s_cur;
        rem_r[k+1]  <= ge ? REM_SQ_W'(rem2 - trial) : REM_SQ_W'(rem2);
        root_r[k+1] <= {root_cur[ROOT_W-2:0], ge};
        side_r[k+1] <= side_cur;
      end
    end
  end

  assign root_out = root_r[SQRT_STEPS];
  assign side_out = side_r[SQRT_STEPS];

endmodule

>>> design/spvk_div.sv
// Pipelined restoring divider with four lanes sharing one divisor: 1/r and |d_i|/r.
// Depends on spvk_pkg; one quotient bit per register stage.
module spvk_div import spvk_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W-1:0] root_in,
  input  spvk_side_t        side_in,
  output logic [QUO_W-1:0]  quo_out [0:DIV_LANES-1],
  output spvk_side_t        side_out
);

  logic [DIV_REM_W-1:0] rem_r  [1:DIV_STEPS][0:DIV_LANES-1];
  logic [QUO_W-1:0]     quo_r  [1:DIV_STEPS][0:DIV_LANES-1];
  logic [ROOT_W-1:0]    root_r [1:DIV_STEPS];
  spvk_side_t           side_r [1:DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
    logic [ROOT_W-1:0] root_cur;
    spvk_side_t        side_cur;

    if (k == 0) begin : g_first
      assign root_cur = root_in;
      assign side_cur = side_in;
    end else begin : g_next
      assign root_cur = root_r[k];
      assign side_cur = side_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k+1] <= root_cur;
        side_r[k+1] <= side_cur;
      end
    end

    for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
      logic [DIV_REM_W-1:0] rem_cur;
      logic [QUO_W-1:0]     quo_cur;
      logic [DIV_REM_W-1:0] rem2;
      logic                 ge;

      // The dividends are 2^86 and |d_i| * 2^70; their low bits are all zero.
      if (k == 0) begin : g_first
        if (l == 0) begin : g_w
          assign rem_cur = DIV_REM_W'(1) << W_INIT_SH;
        end else begin : g_u
          assign rem_cur = DIV_REM_W'(side_in.mag[l-1]) << U_PRESHIFT;
        end
        assign quo_cur = '0;
      end else begin : g_next
        assign rem_cur = rem_r[k][l];
        assign quo_cur = quo_r[k][l];
      end

      assign rem2 = {rem_cur[DIV_REM_W-2:0], 1'b0};
      assign ge   = (rem2 >= {1'b0, root_cur});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1][l] <= ge ? (rem2 - {1'b0, root_cur}) : rem2;
          quo_r[k+1][l] <= {quo_cur[QUO_W-2:0], ge};
        end
      end
    end
  end

  for (genvar l = 0; l < DIV_LANES; l++) begin : g_out
    assign quo_out[l] = quo_r[DIV_STEPS][l];
  end
  assign side_out = side_r[DIV_STEPS];

endmodule

>>> design/spvk_mul.sv
// Three-stage signed multiply, truncating shift toward zero and magnitude clamp.
// Depends on spvk_pkg; built from four 32x32 partial products.
module spvk_mul import spvk_pkg::*; #(
  parameter int                SHIFT   = Q40_SH,
  parameter logic [WORD_W-1:0] CAP_POS = BIG_CAP,
  parameter logic [WORD_W-1:0] CAP_NEG = BIG_CAP
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [WORD_W-1:0] a,
  input  logic signed [WORD_W-1:0] b,
  output logic signed [WORD_W-1:0] p
);

  logic                neg_a_r, neg_b_r;
  logic [WORD_W-1:0]   ma_r, mb_r;
  logic [WORD_W-1:0]   p00_r, p01_r, p10_r, p11_r;
  logic [2*WORD_W-1:0] sum;
  logic [2*WORD_W-1:0] shd;
  logic [WORD_W-1:0]   cap;
  logic [WORD_W-1:0]   mag;
  logic signed [WORD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a_r <= a[WORD_W-1] ^ b[WORD_W-1];
      ma_r    <= a[WORD_W-1] ? (~a + 1'b1) : a;
      mb_r    <= b[WORD_W-1] ? (~b + 1'b1) : b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_b_r <= neg_a_r;
      p00_r   <= {32'd0, ma_r[31:0]}  * {32'd0, mb_r[31:0]};
      p01_r   <= {32'd0, ma_r[31:0]}  * {32'd0, mb_r[63:32]};
      p10_r   <= {32'd0, ma_r[63:32]} * {32'd0, mb_r[31:0]};
      p11_r   <= {32'd0, ma_r[63:32]} * {32'd0, mb_r[63:32]};
    end
  end

  always_comb begin
    sum = {64'd0, p00_r} + ({64'd0, p01_r} << 32) + ({64'd0, p10_r} << 32)
        + {p11_r, 64'd0};
    shd = sum >> SHIFT;
    cap = neg_b_r ? CAP_NEG : CAP_POS;
    mag = ((|shd[2*WORD_W-1:WORD_W]) || (shd[WORD_W-1:0] > cap)) ? cap : shd[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_b_r ? $signed(~mag + 1'b1) : $signed(mag);
    end
  end

  assign p = p_r;

endmodule
